// File: hdl/bbcp_pkg.sv
`default_nettype none
package bbcp_pkg;

    localparam int PROM_AW = 10;
    localparam int CFG_IW  = 2;

    localparam logic [7:0] LAST_ROW   = 8'd223;
    localparam logic [7:0] FULL_SCALE = 8'hff;
    localparam logic [2:0] LAST_PIX   = 3'd7;
    localparam logic [4:0] FLIP_ROWS  = 5'd4;

    typedef enum logic [CFG_IW-1:0] {
        CFG_FLIP_REQUEST     = 2'd0,
        CFG_COCKTAIL_CABINET = 2'd1,
        CFG_RED_SCREEN       = 2'd2
    } cfg_index_t;

    typedef enum logic {
        ACT_VRAM_WRITE = 1'b0,
        ACT_PROM_LOAD  = 1'b1
    } action_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] row;
        logic [4:0] col;
        logic [7:0] bits;
    } bbcp_item_t;

endpackage
`default_nettype wire

// File: hdl/bbcp_fetch.sv
`default_nettype none
module bbcp_fetch (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   action,
    input  wire logic [12:0]            address,
    input  wire logic [7:0]             byte_value,
    input  wire logic                   flip,
    input  wire logic                   take,
    output bbcp_pkg::bbcp_item_t        item,
    output logic [3:0]                  nibble
);

    logic [7:0]                  palette_mem [2**bbcp_pkg::PROM_AW];
    logic [7:0]                  rd_data_reg;
    logic                        a_valid_reg;
    logic                        a_valid_next;
    logic [7:0]                  a_row_reg;
    logic [4:0]                  a_col_reg;
    logic [7:0]                  a_bits_reg;
    logic                        accept;
    logic                        is_load;
    logic [4:0]                  band;
    logic [bbcp_pkg::PROM_AW-1:0] rd_index;

    assign in_ready = !a_valid_reg || take;
    assign accept   = in_valid && in_ready;
    assign is_load  = (action == bbcp_pkg::ACT_PROM_LOAD);
    assign band     = address[12:8];

    always_comb
    begin
        if (flip)
        begin
            rd_index = {5'(band + bbcp_pkg::FLIP_ROWS), address[4:0]};
        end
        else
        begin
            rd_index = {~band, ~address[4:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_load)
        begin
            palette_mem[address[bbcp_pkg::PROM_AW-1:0]] <= byte_value;
        end
        if (accept && !is_load)
        begin
            rd_data_reg <= palette_mem[rd_index];
            a_row_reg   <= address[12:5];
            a_col_reg   <= address[4:0];
            a_bits_reg  <= byte_value;
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg && !take;
        if (accept && !is_load)
        begin
            a_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    assign item.valid = a_valid_reg;
    assign item.row   = a_row_reg;
    assign item.col   = a_col_reg;
    assign item.bits  = a_bits_reg;
    assign nibble     = flip ? rd_data_reg[7:4] : rd_data_reg[3:0];

    a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !take |=> $stable(rd_data_reg) && a_valid_reg)
        else $error("pending lookup lost its read data");

    a_byte_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !action |=> a_valid_reg)
        else $error("accepted byte write not held for expansion");

endmodule
`default_nettype wire

// File: hdl/bbcp_serial.sv
`default_nettype none
module bbcp_serial (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bbcp_pkg::bbcp_item_t   item,
    input  wire logic [3:0]             nibble,
    input  wire logic                   flip,
    input  wire logic                   red_screen,
    output logic                        take,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  pixel_x,
    output logic [7:0]                  pixel_y,
    output logic [3:0]                  color_index,
    output logic [7:0]                  red,
    output logic [7:0]                  green,
    output logic [7:0]                  blue,
    output logic                        last_pixel
);

    logic       valid_reg;
    logic       valid_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [7:0] row_reg;
    logic [4:0] col_reg;
    logic [7:0] bits_reg;
    logic [3:0] nib_reg;
    logic       finish;
    logic       lit;
    logic [7:0] x;

    assign finish = valid_reg && out_ready && (cnt_reg == bbcp_pkg::LAST_PIX);
    assign take   = item.valid && (!valid_reg || finish);

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (valid_reg && out_ready)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (finish)
            begin
                valid_next = 1'b0;
            end
        end
        if (take)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            row_reg  <= item.row;
            col_reg  <= item.col;
            bits_reg <= item.bits;
            nib_reg  <= nibble;
        end
    end

    assign lit         = bits_reg[cnt_reg];
    assign x           = {col_reg, cnt_reg};
    assign out_valid   = valid_reg;
    assign pixel_x     = flip ? ~x : x;
    assign pixel_y     = flip ? 8'(bbcp_pkg::LAST_ROW - row_reg) : row_reg;
    assign color_index = lit ? nib_reg : 4'd0;
    assign red         = (red_screen || color_index[2]) ? bbcp_pkg::FULL_SCALE : 8'd0;
    assign green       = (!red_screen && color_index[1]) ? bbcp_pkg::FULL_SCALE : 8'd0;
    assign blue        = (!red_screen && color_index[0]) ? bbcp_pkg::FULL_SCALE : 8'd0;
    assign last_pixel  = (cnt_reg == bbcp_pkg::LAST_PIX);

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> cnt_reg == 3'd0)
        else $error("pixel counter running with no byte loaded");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !finish |=> valid_reg && $stable(row_reg) && $stable(bits_reg))
        else $error("byte replaced before its eight pixels were sent");

endmodule
`default_nettype wire

// File: hdl/bitmap_byte_color_prom_pixel_expand.sv
// Expands each accepted video RAM byte write into eight pixel transactions,
// least significant bit first, one per cycle on the output channel while
// out_ready is high. A PROM load transaction writes one color PROM entry
// (index from the low 10 address bits) and produces no output. Each byte
// does one read of the 1024x8 color PROM, read into a register when the
// byte is accepted; the next byte is accepted while the current one is
// still being sent. PROM contents are undefined until loaded. Configuration
// writes must happen only while the block is idle.
`default_nettype none
module bitmap_byte_color_prom_pixel_expand (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bbcp_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic                          cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          action,
    input  wire logic [12:0]                   address,
    input  wire logic [7:0]                    byte_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         pixel_x,
    output logic [7:0]                         pixel_y,
    output logic [3:0]                         color_index,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic                               last_pixel
);

    logic                   flip_request_reg;
    logic                   cocktail_reg;
    logic                   red_screen_reg;
    logic                   flip;
    logic                   take;
    logic [3:0]             nibble;
    bbcp_pkg::bbcp_item_t   item;

    assign cfg_ready = 1'b1;
    assign flip      = flip_request_reg && cocktail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_request_reg <= 1'b0;
            cocktail_reg     <= 1'b0;
            red_screen_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bbcp_pkg::CFG_FLIP_REQUEST:     flip_request_reg <= cfg_data;
                bbcp_pkg::CFG_COCKTAIL_CABINET: cocktail_reg     <= cfg_data;
                bbcp_pkg::CFG_RED_SCREEN:       red_screen_reg   <= cfg_data;
                default:                        ;
            endcase
        end
    end

    bbcp_fetch u_fetch (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .address    (address),
        .byte_value (byte_value),
        .flip       (flip),
        .take       (take),
        .item       (item),
        .nibble     (nibble)
    );

    bbcp_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .nibble      (nibble),
        .flip        (flip),
        .red_screen  (red_screen_reg),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .color_index (color_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel)
    );

endmodule
`default_nettype wire

// File: tb/pixel_expand_checker.sv
module pixel_expand_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bbcp_pkg::CFG_IW-1:0]   cfg_index,
    input  logic                          cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          action,
    input  logic [12:0]                   address,
    input  logic [7:0]                    byte_value,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [7:0]                    pixel_x,
    input  logic [7:0]                    pixel_y,
    input  logic [3:0]                    color_index,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic                          last_pixel,
    output int                            fail_count,
    output int                            pending_pixels
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [3:0] color;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
    } pixel_t;

    pixel_t     expected_pixels[$];
    logic [7:0] prom_copy [0:1023];
    logic       flip_req;
    logic       cocktail;
    logic       red_mode;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic expand_byte(input logic [12:0] adr, input logic [7:0] bits);
        logic [7:0] row;
        logic [4:0] col;
        logic [7:0] x;
        logic [9:0] entry;
        logic [3:0] lit;
        logic       flip;
        pixel_t     p;
        flip = flip_req & cocktail;
        row  = adr[12:5];
        col  = adr[4:0];
        // one prom entry serves all eight pixels of the byte
        if (flip)
        begin
            entry = 10'(((int'(row) + 32) / 8) * 32 + int'(col));
            lit   = prom_copy[entry][7:4];
        end
        else
        begin
            entry = 10'((31 - int'(row) / 8) * 32 + (31 - int'(col)));
            lit   = prom_copy[entry][3:0];
        end
        for (int i = 0; i < 8; i++)
        begin
            x       = {col, 3'b000} + 8'(i);
            p.x     = flip ? 8'd255 - x : x;
            p.y     = flip ? 8'd223 - row : row;
            p.color = bits[i] ? lit : 4'd0;
            p.r     = red_mode ? 8'hff : {8{p.color[2]}};
            p.g     = red_mode ? 8'h00 : {8{p.color[1]}};
            p.b     = red_mode ? 8'h00 : {8{p.color[0]}};
            p.last  = (i == 7);
            expected_pixels.push_back(p);
        end
    endtask

    task automatic check_pixel;
        pixel_t want;
        if (expected_pixels.size() == 0)
            report_mismatch($sformatf("pixel (%0d,%0d) with no byte write pending",
                                      pixel_x, pixel_y));
        else
        begin
            want = expected_pixels.pop_front();
            compare_field("pixel_x", pixel_x, want.x);
            compare_field("pixel_y", pixel_y, want.y);
            compare_field("color_index", 8'(color_index), 8'(want.color));
            compare_field("red", red, want.r);
            compare_field("green", green, want.g);
            compare_field("blue", blue, want.b);
            compare_field("last_pixel", 8'(last_pixel), 8'(want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_req = 1'b0;
            cocktail = 1'b0;
            red_mode = 1'b0;
            expected_pixels.delete();
            fail_count = 0;
            pending_pixels <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bbcp_pkg::CFG_FLIP_REQUEST:     flip_req = cfg_data;
                    bbcp_pkg::CFG_COCKTAIL_CABINET: cocktail = cfg_data;
                    bbcp_pkg::CFG_RED_SCREEN:       red_mode = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                check_pixel();
            if (in_valid && in_ready)
            begin
                if (action == bbcp_pkg::ACT_PROM_LOAD)
                    prom_copy[address[9:0]] = byte_value;
                else
                    expand_byte(address, byte_value);
            end
            pending_pixels <= expected_pixels.size();
        end
    end

endmodule

// File: tb/tb_bitmap_byte_color_prom_pixel_expand.sv
module tb_bitmap_byte_color_prom_pixel_expand;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 40;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    bbcp_pkg::cfg_index_t  cfg_index = bbcp_pkg::CFG_FLIP_REQUEST;
    logic                  cfg_data = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    bbcp_pkg::action_t     action = bbcp_pkg::ACT_VRAM_WRITE;
    logic [12:0]           address = '0;
    logic [7:0]            byte_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            pixel_x;
    logic [7:0]            pixel_y;
    logic [3:0]            color_index;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  last_pixel;
    int                    fail_count;
    int                    pending_pixels;

    int          idle_pct = 23;
    int          quiet_cycles = 0;
    bit          flip_now;
    bit          entry_loaded [0:1023];

    bitmap_byte_color_prom_pixel_expand uut (.*);

    pixel_expand_checker pixel_check (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_bitmap_byte_color_prom_pixel_expand: FAIL");
            $finish;
        end
    end

    function automatic logic [9:0] prom_entry_for(input logic [12:0] adr, input bit flip);
        if (flip)
            return 10'(((int'(adr[12:5]) + 32) / 8) * 32 + int'(adr[4:0]));
        return 10'((31 - int'(adr[12:5]) / 8) * 32 + (31 - int'(adr[4:0])));
    endfunction

    task automatic send_item(input bbcp_pkg::action_t act, input logic [12:0] adr,
                             input logic [7:0] dat);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        action     <= act;
        address    <= adr;
        byte_value <= dat;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic load_entry(input logic [12:0] adr, input logic [7:0] dat);
        send_item(bbcp_pkg::ACT_PROM_LOAD, adr, dat);
        entry_loaded[adr[9:0]] = 1'b1;
    endtask

    // never let a byte read a prom entry that was not loaded yet
    task automatic write_byte(input logic [12:0] adr, input logic [7:0] dat);
        logic [9:0] entry;
        entry = prom_entry_for(adr, flip_now);
        if (!entry_loaded[entry])
            load_entry({3'($urandom), entry}, 8'($urandom));
        send_item(bbcp_pkg::ACT_VRAM_WRITE, adr, dat);
    endtask

    task automatic put_reg(input bbcp_pkg::cfg_index_t idx, input logic val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic set_mode(input bit flip_req, input bit cocktail, input bit red_mode);
        put_reg(bbcp_pkg::CFG_FLIP_REQUEST, flip_req);
        put_reg(bbcp_pkg::CFG_COCKTAIL_CABINET, cocktail);
        put_reg(bbcp_pkg::CFG_RED_SCREEN, red_mode);
        cfg_valid <= 1'b0;
        flip_now = flip_req & cocktail;
    endtask

    task automatic settle;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // screen corners, rows past the visible area and alternating bit patterns
    task automatic directed_bytes;
        write_byte(13'd0, 8'hff);
        write_byte(13'd31, 8'h01);
        write_byte(13'd7136, 8'h80);
        write_byte(13'd7167, 8'h00);
        write_byte(13'd7168, 8'haa);
        write_byte(13'h1fff, 8'h55);
        write_byte(13'h1555, 8'h81);
    endtask

    task automatic random_items(input int count);
        logic [12:0] adr;
        logic [7:0]  dat;
        logic [9:0]  entry;
        repeat (count)
        begin
            dat = 8'($urandom);
            case ($urandom_range(0, 9))
                0: dat = 8'h00;
                1: dat = 8'hff;
                default: ;
            endcase
            if ($urandom_range(0, 99) < 25)
                load_entry(13'($urandom), dat);
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    adr = 13'($urandom_range(7168, 8191));
                else
                    adr = 13'($urandom_range(0, 7167));
                // reload the entry right before the byte now and then
                entry = prom_entry_for(adr, flip_now);
                if ($urandom_range(0, 4) == 0)
                    load_entry({3'($urandom), entry}, 8'($urandom));
                write_byte(adr, dat);
            end
        end
    endtask

    task automatic run_phase(input bit flip_req, input bit cocktail, input bit red_mode,
                             input int count);
        settle();
        set_mode(flip_req, cocktail, red_mode);
        random_items(count);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_mode(1'b0, 1'b0, 1'b0);
        load_entry(13'h1fff, 8'hff);
        load_entry(13'h0400, 8'h00);
        directed_bytes();
        settle();
        set_mode(1'b1, 1'b1, 1'b0);
        directed_bytes();
        random_items(PHASE_ITEMS);
        run_phase(1'b1, 1'b0, 1'b0, PHASE_ITEMS);
        idle_pct = 0;
        run_phase(1'b0, 1'b1, 1'b1, PHASE_ITEMS + 20);
        idle_pct = 23;
        run_phase(1'b1, 1'b1, 1'b1, PHASE_ITEMS);
        run_phase(1'b0, 1'b0, 1'b0, PHASE_ITEMS);
        run_phase(1'($urandom), 1'($urandom), 1'($urandom), PHASE_ITEMS);
        settle();
        if (fail_count == 0)
            $display("tb_bitmap_byte_color_prom_pixel_expand: PASS");
        else
            $display("tb_bitmap_byte_color_prom_pixel_expand: FAIL");
        $finish;
    end

endmodule
